// ----- rtl/core/lpm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the prefix-match table core.
// No dependencies; every other file in rtl/core except lpm_ram imports this package.
package lpm_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_W            = 32;
    localparam int LEN_W             = 6;
    localparam int VAL_W             = 8;
    localparam int CNT_OUT_W         = 7;
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [VAL_W-1:0]  route_value;
    } lpm_req_t;

    typedef struct packed {
        logic                 hit;
        logic [VAL_W-1:0]     match_value;
        logic [LEN_W-1:0]     match_len;
        logic                 table_full;
        logic [CNT_OUT_W-1:0] stored_count;
    } lpm_rsp_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [VAL_W-1:0]  value;
    } lpm_entry_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic scan_step;
        logic commit;
    } lpm_cmd_t;

    typedef struct packed {
        logic idx_last;
    } lpm_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } lpm_state_t;

    function automatic logic [LEN_W-1:0] len_clamp(input logic [LEN_W-1:0] len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0)
        begin
            m = '0;
        end
        else
        begin
            m = {ADDR_W{1'b1}} << (MAX_LEN - len);
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/ip_longest_prefix_match_table_core.sv -----
`timescale 1ns / 1ps
// Top level of the IPv4 longest-prefix-match table: controller plus datapath.
// Depends on lpm_pkg, lpm_ctrl, lpm_datapath and lpm_ram.
//
//  channel   handshake        payload   transfer when
//  --------  ---------------  --------  ------------------------------
//  request   start / busy     request   rising edge with start & !busy
//  result    done (strobe)    result    rising edge ending the done cycle
//
// Each operation runs these steps from transfer to done strobe: one read
// per table entry from the single entry RAM read port, a drain state for
// the last read data, a write-back state, then the registered result.
// After reset a clearing pass writes every entry once with busy high.
// The result is shown for one cycle; the receiver cannot stall.
module ip_longest_prefix_match_table_core #(
    parameter int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lpm_pkg::lpm_req_t request,
    output logic              done,
    output lpm_pkg::lpm_rsp_t result
);
    import lpm_pkg::*;

    lpm_cmd_t    cmd;
    lpm_status_t status;

    lpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    lpm_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .request(request),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule

// ----- rtl/core/lpm_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lpm_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the clearing pass after reset and the scan, drain and commit of each table operation.
// Depends on lpm_pkg.
module lpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lpm_pkg::lpm_status_t status,
    output lpm_pkg::lpm_cmd_t    cmd,
    output logic                busy
);
    import lpm_pkg::*;

    lpm_state_t state_reg;
    lpm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_step, cmd.load, cmd.scan_step, cmd.commit}))
        else $error("more than one datapath command at once");

    a_scan_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.idx_last) |=> (state_reg == ST_DRAIN))
        else $error("scan did not stop at the last entry");

    a_commit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> ($past(state_reg) == ST_DRAIN))
        else $error("commit without a drain cycle");
`endif

endmodule

// ----- rtl/core/lpm_datapath.sv -----
`timescale 1ns / 1ps
// Entry store, scan comparators, write-back and result registers.
// Depends on lpm_pkg and lpm_ram.
module lpm_datapath #(
    parameter int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpm_pkg::lpm_cmd_t    cmd,
    input  lpm_pkg::lpm_req_t    request,
    output lpm_pkg::lpm_status_t status,
    output logic                 done,
    output lpm_pkg::lpm_rsp_t    result
);
    import lpm_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = $bits(lpm_entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    lpm_req_t          op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              exact_found_reg, exact_found_next;
    logic [IDX_W-1:0]  exact_idx_reg, exact_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              best_hit_reg, best_hit_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic [VAL_W-1:0]  best_val_reg, best_val_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg;
    lpm_rsp_t          result_reg, result_next;

    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    lpm_entry_t         rd_entry;
    lpm_entry_t         wb_entry;
    logic [LEN_W-1:0]   req_len;
    logic               is_exact, is_free, is_cover;
    logic               is_add, is_remove, is_find;
    logic               commit_wr;
    logic [IDX_W-1:0]   commit_idx;
    logic [CNT_W+CNT_OUT_W-1:0] count_ext;

    lpm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (cmd.scan_step),
        .rd_addr(idx_reg),
        .rd_data(rd_data)
    );

    assign rd_entry        = lpm_entry_t'(rd_data);
    assign status.idx_last = (idx_reg == LAST_IDX);

    // capture the operation, clamping the prefix length and masking the prefix for every mode but find
    always_comb
    begin
        req_len            = len_clamp(request.prefix_len);
        op_next            = request;
        op_next.prefix_len = req_len;
        if (request.mode != MODE_FIND)
        begin
            op_next.address = request.address & len_mask(req_len);
        end
    end

    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.clear_step || cmd.scan_step)
        begin
            idx_next = status.idx_last ? '0 : idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign is_exact = rd_entry.valid && (rd_entry.length == op_reg.prefix_len)
                      && (rd_entry.prefix == op_reg.address);
    assign is_free  = !rd_entry.valid;
    assign is_cover = rd_entry.valid
                      && ((op_reg.address & len_mask(rd_entry.length)) == rd_entry.prefix);

    // accumulate scan results as read data returns
    always_comb
    begin
        exact_found_next = exact_found_reg;
        exact_idx_next   = exact_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        best_hit_next    = best_hit_reg;
        best_len_next    = best_len_reg;
        best_val_next    = best_val_reg;
        if (cmd.load)
        begin
            exact_found_next = 1'b0;
            free_found_next  = 1'b0;
            best_hit_next    = 1'b0;
            best_len_next    = '0;
            best_val_next    = '0;
        end
        else if (rd_valid_reg)
        begin
            if (is_exact && !exact_found_reg)
            begin
                exact_found_next = 1'b1;
                exact_idx_next   = rd_idx_reg;
            end
            if (is_free && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
            if (is_cover && (!best_hit_reg || rd_entry.length > best_len_reg))
            begin
                best_hit_next = 1'b1;
                best_len_next = rd_entry.length;
                best_val_next = rd_entry.value;
            end
        end
    end

    assign is_add    = (op_reg.mode == MODE_ADD);
    assign is_remove = (op_reg.mode == MODE_REMOVE);
    assign is_find   = (op_reg.mode == MODE_FIND);

    assign commit_idx = exact_found_reg ? exact_idx_reg : free_idx_reg;
    assign commit_wr  = cmd.commit && ((is_add && (exact_found_reg || free_found_reg))
                                       || (is_remove && exact_found_reg));

    always_comb
    begin
        wb_entry.valid  = is_add;
        wb_entry.prefix = op_reg.address;
        wb_entry.length = op_reg.prefix_len;
        wb_entry.value  = op_reg.route_value;
    end

    assign wr_en   = cmd.clear_step || commit_wr;
    assign wr_addr = cmd.clear_step ? idx_reg : commit_idx;
    assign wr_data = cmd.clear_step ? '0 : ENTRY_W'(wb_entry);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            if (is_add && !exact_found_reg && free_found_reg)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (is_remove && exact_found_reg && count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    assign count_ext = {{CNT_OUT_W{1'b0}}, count_next};

    always_comb
    begin
        result_next              = '0;
        result_next.hit          = (is_remove && exact_found_reg) || (is_find && best_hit_reg);
        result_next.match_value  = is_find ? best_val_reg : '0;
        result_next.match_len    = is_find ? best_len_reg : '0;
        result_next.table_full   = is_add && !exact_found_reg && !free_found_reg;
        result_next.stored_count = count_ext[CNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            rd_valid_reg    <= 1'b0;
            exact_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_hit_reg    <= 1'b0;
            count_reg       <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            idx_reg         <= idx_next;
            rd_valid_reg    <= cmd.scan_step;
            exact_found_reg <= exact_found_next;
            free_found_reg  <= free_found_next;
            best_hit_reg    <= best_hit_next;
            count_reg       <= count_next;
            done_reg        <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= idx_reg;
        exact_idx_reg <= exact_idx_next;
        free_idx_reg  <= free_idx_next;
        best_len_reg  <= best_len_next;
        best_val_reg  <= best_val_next;
        if (cmd.load)
        begin
            op_reg <= op_next;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("stored prefix count above table size");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full)
        |-> (result.stored_count == CNT_OUT_W'(TABLE_ENTRIES)))
        else $error("table full reported while entries remain");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.match_len <= MAX_LEN))
        else $error("match length above 32");

    a_scan_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |=> rd_valid_reg)
        else $error("scan read data not marked valid");
`endif

endmodule
